>>> hdl/matrix2x2_frame_rotation_macros.svh
// Assertion macros for the frame rotation block
`ifndef MATRIX2X2_FRAME_ROTATION_MACROS_SVH
`define MATRIX2X2_FRAME_ROTATION_MACROS_SVH

// same-cycle implication
`define MR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/mr_pkg.sv
package mr_pkg;

  localparam int CordicStagesDef = 24;
  localparam int EntryWidthDef   = 32;
  localparam int FieldW          = 32;
  localparam int AngleW          = 16;
  localparam int PhaseW          = 34;
  localparam int TrigW           = 34;
  localparam int FracBits        = 30;

  localparam logic signed [TrigW-1:0] CordicX0     = 34'sd652032875;
  localparam logic signed [PhaseW-1:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [PhaseW-1:0] HalfTurn    = 34'sd2147483648;

  function automatic logic [31:0] atan_angle(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/matrix2x2_frame_rotation.sv
// channel | handshake              | payload
// in      | in_valid_i, in_ready_o | angle_i, in_top_left_i, in_top_right_i,
//         |                        | in_bottom_right_i, in_bottom_left_i
// out     | out_valid_o, out_ready_i | out_top_left_o, out_top_right_o,
//         |                        | out_bottom_right_o, out_bottom_left_o
// One word per cycle while the output does not stall; the pipeline registers are the
// input fold register, one register per CORDIC stage, two multiply stages and two sum stages.
// Reset clears only the valid bits; the data registers are not reset.
// A stall at the output freezes the whole pipeline; in_ready_o drops with it.
`include "matrix2x2_frame_rotation_macros.svh"

module matrix2x2_frame_rotation #(
  parameter int CORDIC_STAGES = mr_pkg::CordicStagesDef,
  parameter int ENTRY_WIDTH   = mr_pkg::EntryWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mr_pkg::AngleW-1:0]         angle_i,
  input  logic signed [mr_pkg::FieldW-1:0]  in_top_left_i,
  input  logic signed [mr_pkg::FieldW-1:0]  in_top_right_i,
  input  logic signed [mr_pkg::FieldW-1:0]  in_bottom_right_i,
  input  logic signed [mr_pkg::FieldW-1:0]  in_bottom_left_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mr_pkg::FieldW-1:0]  out_top_left_o,
  output logic signed [mr_pkg::FieldW-1:0]  out_top_right_o,
  output logic signed [mr_pkg::FieldW-1:0]  out_bottom_right_o,
  output logic signed [mr_pkg::FieldW-1:0]  out_bottom_left_o
);

  localparam int N  = CORDIC_STAGES;
  localparam int EW = (ENTRY_WIDTH < mr_pkg::FieldW) ? ENTRY_WIDTH : mr_pkg::FieldW;
  localparam int TW = mr_pkg::TrigW;
  localparam int FB = mr_pkg::FracBits;
  localparam int PW = mr_pkg::PhaseW;
  localparam int P1 = EW + TW - FB;
  localparam int QW = P1 + 1;
  localparam int P2 = QW + TW - FB;
  localparam int RW = P2 + 1;
  localparam int NV = N + 5;

  logic          en;
  logic [NV-1:0] vld_q;

  assign en          = !vld_q[NV-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  logic signed [TW-1:0] cx_q [N+1];
  logic signed [TW-1:0] cy_q [N+1];
  logic signed [PW-1:0] cz_q [N+1];
  logic                 cf_q [N+1];
  logic signed [EW-1:0] ent_q [N+1][4];

  logic signed [PW-1:0] z_raw;
  logic signed [PW-1:0] z_fold;
  logic                 flip;

  always_comb begin
    z_raw = PW'($signed({angle_i, 16'b0}));
    flip  = 1'b0;
    z_fold = z_raw;
    if (z_raw > mr_pkg::QuarterTurn) begin
      z_fold = z_raw - mr_pkg::HalfTurn;
      flip   = 1'b1;
    end else if (z_raw < -mr_pkg::QuarterTurn) begin
      z_fold = z_raw + mr_pkg::HalfTurn;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0]     <= mr_pkg::CordicX0;
      cy_q[0]     <= '0;
      cz_q[0]     <= z_fold;
      cf_q[0]     <= flip;
      ent_q[0][0] <= $signed(in_top_left_i[EW-1:0]);
      ent_q[0][1] <= $signed(in_top_right_i[EW-1:0]);
      ent_q[0][2] <= $signed(in_bottom_right_i[EW-1:0]);
      ent_q[0][3] <= $signed(in_bottom_left_i[EW-1:0]);
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cordic
    localparam logic signed [PW-1:0] Atan = PW'(mr_pkg::atan_angle(k));
    logic signed [TW-1:0] dx;
    logic signed [TW-1:0] dy;
    assign dx = cy_q[k] >>> k;
    assign dy = cx_q[k] >>> k;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (cz_q[k] >= 0) begin
          cx_q[k+1] <= cx_q[k] - dx;
          cy_q[k+1] <= cy_q[k] + dy;
          cz_q[k+1] <= cz_q[k] - Atan;
        end else begin
          cx_q[k+1] <= cx_q[k] + dx;
          cy_q[k+1] <= cy_q[k] - dy;
          cz_q[k+1] <= cz_q[k] + Atan;
        end
        cf_q[k+1]  <= cf_q[k];
        ent_q[k+1] <= ent_q[k];
      end
    end
  end

  logic signed [TW-1:0] cs_d, sn_d, ns_d;
  assign cs_d = cf_q[N] ? -cx_q[N] : cx_q[N];
  assign sn_d = cf_q[N] ? -cy_q[N] : cy_q[N];
  assign ns_d = -sn_d;

  // first product: Q = P * R(-t)
  logic signed [EW-1:0] m1_a [8];
  logic signed [TW-1:0] m1_b [8];
  logic signed [P1-1:0] p1_d [8];
  logic signed [P1-1:0] p1_q [8];
  logic signed [TW-1:0] c1_q, s1_q, n1_q;

  always_comb begin
    m1_a[0] = ent_q[N][0]; m1_b[0] = cs_d;
    m1_a[1] = ent_q[N][1]; m1_b[1] = ns_d;
    m1_a[2] = ent_q[N][0]; m1_b[2] = sn_d;
    m1_a[3] = ent_q[N][1]; m1_b[3] = cs_d;
    m1_a[4] = ent_q[N][3]; m1_b[4] = sn_d;
    m1_a[5] = ent_q[N][2]; m1_b[5] = cs_d;
    m1_a[6] = ent_q[N][3]; m1_b[6] = cs_d;
    m1_a[7] = ent_q[N][2]; m1_b[7] = ns_d;
    for (int i = 0; i < 8; i++) begin
      p1_d[i] = P1'(((EW+TW)'(m1_a[i]) * (EW+TW)'(m1_b[i])) >>> FB);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      c1_q <= cs_d;
      s1_q <= sn_d;
      n1_q <= ns_d;
    end
  end

  logic signed [QW-1:0] q_q [4];
  logic signed [TW-1:0] c2_q, s2_q, n2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        q_q[i] <= QW'(p1_q[2*i]) + QW'(p1_q[2*i+1]);
      end
      c2_q <= c1_q;
      s2_q <= s1_q;
      n2_q <= n1_q;
    end
  end

  // second product: R(t) * Q; q_q order is qa, qb, qc, qd
  logic signed [QW-1:0] m2_a [8];
  logic signed [TW-1:0] m2_b [8];
  logic signed [P2-1:0] p2_d [8];
  logic signed [P2-1:0] p2_q [8];

  always_comb begin
    m2_a[0] = q_q[0]; m2_b[0] = c2_q;
    m2_a[1] = q_q[3]; m2_b[1] = n2_q;
    m2_a[2] = q_q[1]; m2_b[2] = c2_q;
    m2_a[3] = q_q[2]; m2_b[3] = n2_q;
    m2_a[4] = q_q[1]; m2_b[4] = s2_q;
    m2_a[5] = q_q[2]; m2_b[5] = c2_q;
    m2_a[6] = q_q[0]; m2_b[6] = s2_q;
    m2_a[7] = q_q[3]; m2_b[7] = c2_q;
    for (int i = 0; i < 8; i++) begin
      p2_d[i] = P2'(((QW+TW)'(m2_a[i]) * (QW+TW)'(m2_b[i])) >>> FB);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q <= p2_d;
    end
  end

  localparam logic signed [RW-1:0] SatMax = RW'((64'sd1 <<< (EW-1)) - 64'sd1);
  localparam logic signed [RW-1:0] SatMin = RW'(-(64'sd1 <<< (EW-1)));

  logic signed [RW-1:0]             r_sum [4];
  logic signed [EW-1:0]             r_sat [4];
  logic signed [mr_pkg::FieldW-1:0] r_q [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r_sum[i] = RW'(p2_q[2*i]) + RW'(p2_q[2*i+1]);
      if (r_sum[i] > SatMax) begin
        r_sat[i] = SatMax[EW-1:0];
      end else if (r_sum[i] < SatMin) begin
        r_sat[i] = SatMin[EW-1:0];
      end else begin
        r_sat[i] = r_sum[i][EW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        r_q[i] <= mr_pkg::FieldW'(r_sat[i]);
      end
    end
  end

  assign out_top_left_o     = r_q[0];
  assign out_top_right_o    = r_q[1];
  assign out_bottom_right_o = r_q[2];
  assign out_bottom_left_o  = r_q[3];

  `MR_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, vld_q[0])
  `MR_ASSERT_NEXT(a_stall_freezes, out_valid_o && !out_ready_i, $stable(vld_q))
  `MR_ASSERT_NOW(a_ready_on_space, !out_valid_o, in_ready_o)

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Stages   = mr_pkg::CordicStagesDef;
  localparam int Latency  = Stages + 5;
  localparam int NumRand  = 1600;
  localparam int MaxCycle = 400000;

  typedef struct packed {
    logic [15:0]        angle;
    logic signed [31:0] tl;
    logic signed [31:0] tr;
    logic signed [31:0] br;
    logic signed [31:0] bl;
  } mat_word_t;

  typedef struct packed {
    logic signed [31:0] tl;
    logic signed [31:0] tr;
    logic signed [31:0] br;
    logic signed [31:0] bl;
  } rot_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o;
  logic [15:0] angle_i = '0;
  logic signed [31:0] in_top_left_i = '0, in_top_right_i = '0;
  logic signed [31:0] in_bottom_right_i = '0, in_bottom_left_i = '0;
  logic signed [31:0] out_top_left_o, out_top_right_o, out_bottom_right_o, out_bottom_left_o;

  mat_word_t pending_words[$];
  rot_word_t rotated_expect[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle = 26, recv_idle = 63;
  int hold_off = 0;

  matrix2x2_frame_rotation dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic logic signed [63:0] mul_trig(logic signed [63:0] x,
                                                  logic signed [63:0] s);
    logic signed [127:0] p;
    p = 128'(x) * 128'(s);
    return 64'(p >>> 30);
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic rot_word_t rotate_frame(mat_word_t w);
    logic signed [63:0] z, x, y, dx, dy, c, s, ns;
    logic signed [63:0] qa, qb, qc, qd;
    rot_word_t r;
    bit flip;
    z = {w.angle, 16'h0};
    x = 64'sd652032875;
    y = 0;
    flip = 1'b0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1'b1;
    end
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= 64'(mr_pkg::atan_angle(i));
      end else begin
        x += dx;
        y -= dy;
        z += 64'(mr_pkg::atan_angle(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    ns = -s;
    qa = mul_trig(w.tl, c) + mul_trig(w.tr, ns);
    qb = mul_trig(w.tl, s) + mul_trig(w.tr, c);
    qc = mul_trig(w.bl, s) + mul_trig(w.br, c);
    qd = mul_trig(w.bl, c) + mul_trig(w.br, ns);
    r.tl = clamp32(mul_trig(qa, c) + mul_trig(qd, ns));
    r.tr = clamp32(mul_trig(qb, c) + mul_trig(qc, ns));
    r.br = clamp32(mul_trig(qb, s) + mul_trig(qc, c));
    r.bl = clamp32(mul_trig(qa, s) + mul_trig(qd, c));
    return r;
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(logic [15:0] a, logic [31:0] tl, logic [31:0] tr,
                           logic [31:0] br, logic [31:0] bl);
    mat_word_t w;
    w = '{a, tl, tr, br, bl};
    pending_words.push_back(w);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        rotated_expect.push_back(rotate_frame({angle_i, in_top_left_i, in_top_right_i,
                                               in_bottom_right_i, in_bottom_left_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          mat_word_t w;
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          angle_i <= w.angle;
          in_top_left_i <= w.tl;
          in_top_right_i <= w.tr;
          in_bottom_right_i <= w.br;
          in_bottom_left_i <= w.bl;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rot_word_t got, want;
        got = '{out_top_left_o, out_top_right_o, out_bottom_right_o, out_bottom_left_o};
        if (rotated_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          want = rotated_expect.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch expected %h actual %h", want, got);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycle) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    push_word(16'h0000, 32'h00010000, 32'h0, 32'h00010000, 32'h0);
    push_word(16'h4000, 32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000);
    push_word(16'h8000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    push_word(16'hc000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    push_word(16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    push_word(16'h2000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    push_word(16'h6000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    push_word(16'h4001, 32'h12345678, 32'hedcba987, 32'h0, 32'h55555555);
    push_word(16'h3fff, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
    push_word(16'hbfff, 32'h0, 32'h0, 32'h0, 32'h0);
    push_word(16'hc001, 32'h00000001, 32'hfffffffe, 32'h7fff0000, 32'h8000ffff);
    push_word(16'h5555, 32'hffffffff, 32'h0, 32'h7fffffff, 32'h80000000);
    for (int i = 0; i < NumRand; i++) begin
      if (i == NumRand / 3) begin
        wait (pending_words.size() == 0);
        send_idle = 63;
        recv_idle = 26;
        hold_off = 300;
      end
      if (i == 2 * NumRand / 3) begin
        wait (pending_words.size() == 0);
        send_idle = 0;
        recv_idle = 0;
      end
      push_word($urandom, rand_entry(), rand_entry(), rand_entry(), rand_entry());
    end
    wait (pending_words.size() == 0 && !in_valid_i);
    wait (rotated_expect.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0 && rotated_expect.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
